/* rtl/linear_queue_min_max_search_defines.svh */
// Assertion macros for the linear queue with min/max and search.
`ifndef LINEAR_QUEUE_MIN_MAX_SEARCH_DEFINES_SVH
`define LINEAR_QUEUE_MIN_MAX_SEARCH_DEFINES_SVH

// Condition and consequence in the same cycle.
`define LQMM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lqmm: same-cycle check failed");

// Consequence in the cycle after the condition.
`define LQMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lqmm: next-cycle check failed");

`endif

/* rtl/lqmm_pkg.sv */
// Shared types and constants for the linear queue with min/max and search.
`timescale 1ns / 1ps
package lqmm_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 8;
  localparam int FOUND_W   = 3;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_MINMAX = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_e;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic en;     // take the current entry into the running min/max
    logic first;  // current entry is the head entry
  } scan_ctl_t;

endpackage

/* rtl/lqmm_if.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface lqmm_req_if;
  import lqmm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface lqmm_rsp_if;
  import lqmm_pkg::*;
  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic signed [DATA_W-1:0] data_out;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] max_value;
  logic [FOUND_W-1:0]       found_index;

  modport source (output valid, output status, output data_out, output min_value,
                  output max_value, output found_index, input ready);
  modport sink   (input valid, input status, input data_out, input min_value,
                  input max_value, input found_index, output ready);
endinterface

/* rtl/linear_queue_min_max_search.sv */
// Top level of the linear queue with min/max query and search.
`timescale 1ns / 1ps
// Linear (non-circular) queue of DEPTH signed bytes, one response per
// request. Enqueue writes after the tail and answers "full" once the tail
// sits on the last slot, even if slots ahead of the head are free; dequeue
// hands out the head item, and taking the last item returns the queue to
// its empty reset position. Min/max walks the live entries head..tail with
// signed compares; search gives the storage index (low 3 bits) of the
// first live match, or "not found". Any request but enqueue on an empty
// queue answers "empty" with all data fields zero; unused fields are zero.
// Enqueue and every "empty"/"full" answer go straight into the response
// register; dequeue reads the head slot, then hands it out; min/max walks
// all live entries and search stops at the first match (or at the tail).
// Reads use the single registered read port of the slot array, walked one
// entry a cycle through one shared compare unit; one request is in flight
// at a time. The response sits in an output register; a new request is
// taken only when that register is empty or its response leaves in the
// same cycle, so a response held by the sink stalls the request side. No
// clearing pass after reset: read data is used only from written slots.
module linear_queue_min_max_search #(
  parameter int DEPTH = lqmm_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lqmm_req_if.sink   req_i,
  lqmm_rsp_if.source rsp_o
);
  import lqmm_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  scan_ctl_t                scan_ctl;
  logic signed [DATA_W-1:0] scan_target;
  logic signed [DATA_W-1:0] scan_lo;
  logic signed [DATA_W-1:0] scan_hi;
  logic                     scan_match;

  // slot array, one entry written and one read per cycle
  lqmm_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit: fed the registered read data each scan cycle
  lqmm_scan u_scan (
    .clk_i    (clk_i),
    .ctl_i    (scan_ctl),
    .data_i   (mem_rdata),
    .target_i (scan_target),
    .lo_o     (scan_lo),
    .hi_o     (scan_hi),
    .match_o  (scan_match)
  );

  // sequencer, pointers and response register
  lqmm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .scan_ctl_o    (scan_ctl),
    .scan_target_o (scan_target),
    .scan_lo_i     (scan_lo),
    .scan_hi_i     (scan_hi),
    .scan_match_i  (scan_match)
  );

endmodule

/* rtl/lqmm_mem.sv */
// Slot storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module lqmm_mem #(
  parameter int DEPTH = lqmm_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic signed [lqmm_pkg::DATA_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic signed [lqmm_pkg::DATA_W-1:0] rdata_o
);
  import lqmm_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lqmm_scan.sv */
// Shared compare unit: running signed min/max and equality match.
`timescale 1ns / 1ps
module lqmm_scan (
  input  logic                               clk_i,
  input  lqmm_pkg::scan_ctl_t                ctl_i,
  input  logic signed [lqmm_pkg::DATA_W-1:0] data_i,
  input  logic signed [lqmm_pkg::DATA_W-1:0] target_i,
  output logic signed [lqmm_pkg::DATA_W-1:0] lo_o,
  output logic signed [lqmm_pkg::DATA_W-1:0] hi_o,
  output logic                               match_o
);
  import lqmm_pkg::*;

  logic signed [DATA_W-1:0] lo_q, lo_d;
  logic signed [DATA_W-1:0] hi_q, hi_d;

  always_comb begin
    if (ctl_i.first) begin
      lo_d = data_i;
      hi_d = data_i;
    end else begin
      lo_d = (data_i < lo_q) ? data_i : lo_q;
      hi_d = (data_i > hi_q) ? data_i : hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o    = lo_d;
  assign hi_o    = hi_d;
  assign match_o = (data_i == target_i);

endmodule

/* rtl/lqmm_ctrl.sv */
// Sequencer: queue pointers, scan walk and the response register.
`timescale 1ns / 1ps
module lqmm_ctrl #(
  parameter int DEPTH = lqmm_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lqmm_req_if.sink                           req_i,
  lqmm_rsp_if.source                         rsp_o,
  output logic                               mem_we_o,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr_o,
  output logic signed [lqmm_pkg::DATA_W-1:0] mem_wdata_o,
  output logic                               mem_re_o,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr_o,
  input  logic signed [lqmm_pkg::DATA_W-1:0] mem_rdata_i,
  output lqmm_pkg::scan_ctl_t                scan_ctl_o,
  output logic signed [lqmm_pkg::DATA_W-1:0] scan_target_o,
  input  logic signed [lqmm_pkg::DATA_W-1:0] scan_lo_i,
  input  logic signed [lqmm_pkg::DATA_W-1:0] scan_hi_i,
  input  logic                               scan_match_i
);
  import lqmm_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int FW   = (IW > FOUND_W) ? IW : FOUND_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  state_e                   state_q, state_d;
  logic [IW-1:0]            head_q, head_d;
  logic [IW-1:0]            tail_q, tail_d;
  logic                     empty_q, empty_d;
  logic [IW-1:0]            ptr_q, ptr_d;
  logic [IW-1:0]            cidx_q, cidx_d;
  req_e                     op_q, op_d;
  logic signed [DATA_W-1:0] target_q, target_d;

  logic                     out_vld_q, out_vld_d;
  status_e                  out_stat_q, out_stat_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic signed [DATA_W-1:0] out_min_q, out_min_d;
  logic signed [DATA_W-1:0] out_max_q, out_max_d;
  logic [FOUND_W-1:0]       out_fidx_q, out_fidx_d;

  logic       out_free;
  logic       acc;
  logic       finish;
  req_e       req;
  logic [FW-1:0] cidx_wide;

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign acc       = req_i.valid && req_i.ready;
  assign req       = req_e'(req_i.req_type);
  assign finish    = (cidx_q == tail_q) || ((op_q == REQ_SEARCH) && scan_match_i);
  assign cidx_wide = FW'(cidx_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && !empty_q) begin
          if (req == REQ_DEQ) begin
            state_d = S_DEQ;
          end else if (req != REQ_ENQ) begin
            state_d = S_SCAN;
          end
        end
      end
      S_DEQ: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (finish && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    ptr_d      = ptr_q;
    cidx_d     = cidx_q;
    op_d       = op_q;
    target_d   = target_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_stat_d = out_stat_q;
    out_data_d = out_data_q;
    out_min_d  = out_min_q;
    out_max_d  = out_max_q;
    out_fidx_d = out_fidx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = req_i.data_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    scan_ctl_o  = '{en: 1'b0, first: (cidx_q == head_q)};

    case (state_q)
      S_IDLE: begin
        mem_re_o = 1'b1;
        if (acc) begin
          op_d     = req;
          target_d = req_i.data_in;
          cidx_d   = head_q;
          ptr_d    = head_q + IW'(1);
          if (req == REQ_ENQ || empty_q) begin
            // answered at once
            out_vld_d  = 1'b1;
            out_stat_d = STAT_OK;
            out_data_d = '0;
            out_min_d  = '0;
            out_max_d  = '0;
            out_fidx_d = '0;
            if (req != REQ_ENQ) begin
              out_stat_d = STAT_EMPTY;
            end else if (empty_q) begin
              head_d      = '0;
              tail_d      = '0;
              empty_d     = 1'b0;
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
            end else if (tail_q == LAST) begin
              out_stat_d = STAT_FULL;
            end else begin
              tail_d      = tail_q + IW'(1);
              mem_we_o    = 1'b1;
              mem_waddr_o = tail_q + IW'(1);
            end
          end else if (req == REQ_DEQ) begin
            // head entry is read at this edge, handed out from S_DEQ once the response register is free
            if (head_q == tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else begin
              head_d = head_q + IW'(1);
            end
          end
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_stat_d = STAT_OK;
          out_data_d = mem_rdata_i;
          out_min_d  = '0;
          out_max_d  = '0;
          out_fidx_d = '0;
        end
      end
      S_SCAN: begin
        mem_raddr_o = ptr_q;
        if (!finish) begin
          mem_re_o      = 1'b1;
          scan_ctl_o.en = 1'b1;
          cidx_d        = ptr_q;
          ptr_d         = ptr_q + IW'(1);
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_stat_d = STAT_OK;
          out_data_d = '0;
          out_min_d  = '0;
          out_max_d  = '0;
          out_fidx_d = '0;
          if (op_q == REQ_MINMAX) begin
            out_min_d = scan_lo_i;
            out_max_d = scan_hi_i;
          end else if (scan_match_i) begin
            out_fidx_d = cidx_wide[FOUND_W-1:0];
          end else begin
            out_stat_d = STAT_NOTFOUND;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    cidx_q     <= cidx_d;
    op_q       <= op_d;
    target_q   <= target_d;
    out_stat_q <= out_stat_d;
    out_data_q <= out_data_d;
    out_min_q  <= out_min_d;
    out_max_q  <= out_max_d;
    out_fidx_q <= out_fidx_d;
  end

  assign scan_target_o     = target_q;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.data_out    = out_data_q;
  assign rsp_o.min_value   = out_min_q;
  assign rsp_o.max_value   = out_max_q;
  assign rsp_o.found_index = out_fidx_q;

endmodule

/* rtl/lqmm_chk.sv */
// Port-level checker for the linear queue, bound to the top level.
`timescale 1ns / 1ps
`include "linear_queue_min_max_search_defines.svh"
module lqmm_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_valid_i,
  input logic                               req_ready_i,
  input logic [1:0]                         req_type_i,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic [1:0]                         rsp_status_i,
  input logic signed [lqmm_pkg::DATA_W-1:0] rsp_data_i,
  input logic signed [lqmm_pkg::DATA_W-1:0] rsp_min_i,
  input logic signed [lqmm_pkg::DATA_W-1:0] rsp_max_i
);
  import lqmm_pkg::*;

  // a stalled response stays and holds its status, data and minimum
  `LQMM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `LQMM_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_status_i) && $stable(rsp_data_i) && $stable(rsp_min_i))
  // an enqueue is answered in the very next cycle
  `LQMM_ASSERT_NEXT(a_enq_quick, clk_i, rst_ni, req_valid_i && req_ready_i && (req_type_i == REQ_ENQ), rsp_valid_i)
  // the minimum never exceeds the maximum (both zero when unused)
  `LQMM_ASSERT_NOW(a_min_le_max, clk_i, rst_ni, rsp_valid_i, rsp_min_i <= rsp_max_i)

endmodule

bind linear_queue_min_max_search lqmm_chk u_lqmm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.data_out),
  .rsp_min_i    (rsp_o.min_value),
  .rsp_max_i    (rsp_o.max_value)
);
